/* rtl/core/touch_key_frame_press_classifier_assert.svh */
`ifndef TOUCH_KEY_FRAME_PRESS_CLASSIFIER_ASSERT_SVH
`define TOUCH_KEY_FRAME_PRESS_CLASSIFIER_ASSERT_SVH

// same-cycle implication
`define TKP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TKP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/tkp_pkg.sv */
package tkp_pkg;

  localparam int COUNT_W = 4;
  localparam int STOP_W  = 3;

  localparam logic [STOP_W-1:0]  VALID_STOP  = 3'd2;
  localparam logic [COUNT_W-1:0] COUNT_LIMIT = 4'd5;

  localparam logic [15:0] LONG_PRESS_RESET = 16'd20;

  localparam int OUT_KEYS = 8;

  typedef enum logic [1:0] {
    CLS_NONE  = 2'd0,
    CLS_SHORT = 2'd1,
    CLS_LONG  = 2'd2
  } press_cls_t;

  typedef struct packed {
    logic               done;
    logic               valid;
    logic [COUNT_W-1:0] count;
    logic [STOP_W-1:0]  stop;
  } frame_info_t;

endpackage

/* rtl/core/tkp_rx.sv */
module tkp_rx
  import tkp_pkg::*;
#(
  parameter int KEYS = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_acc,
  input  logic            op,
  input  logic            line_level,
  output logic            at_last,
  output logic [KEYS-1:0] frame_keys,
  output frame_info_t     frame_info
);

  localparam int FRAME_BITS = KEYS + COUNT_W + STOP_W;
  localparam int POS_W      = $clog2(FRAME_BITS + 1);

  logic [POS_W-1:0]   bit_position, bit_position_next;
  logic [KEYS-1:0]    key_shift, key_shift_next;
  logic [COUNT_W-1:0] count_shift, count_shift_next;
  logic [STOP_W-1:0]  stop_shift, stop_shift_next;
  logic               done;

  assign at_last = (bit_position == POS_W'(FRAME_BITS - 1));

  always_comb begin
    bit_position_next = bit_position;
    key_shift_next    = key_shift;
    count_shift_next  = count_shift;
    stop_shift_next   = stop_shift;
    done              = 1'b0;
    if (in_acc) begin
      if (!op) begin
        bit_position_next = '0;
        key_shift_next    = '0;
        count_shift_next  = '0;
        stop_shift_next   = '0;
      end else if (bit_position < POS_W'(FRAME_BITS)) begin
        // key lines are active low, count and stop come lsb first
        for (int k = 0; k < KEYS; k++) begin
          if (bit_position == POS_W'(k)) begin
            key_shift_next[k] = key_shift[k] | ~line_level;
          end
        end
        for (int j = 0; j < COUNT_W; j++) begin
          if (bit_position == POS_W'(KEYS + j)) begin
            count_shift_next[j] = count_shift[j] | line_level;
          end
        end
        for (int j = 0; j < STOP_W; j++) begin
          if (bit_position == POS_W'(KEYS + COUNT_W + j)) begin
            stop_shift_next[j] = stop_shift[j] | line_level;
          end
        end
        bit_position_next = bit_position + 1'b1;
        done              = at_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_position    <= '0;
      key_shift       <= '0;
      count_shift     <= '0;
      stop_shift      <= '0;
      frame_info.done <= 1'b0;
    end else begin
      bit_position    <= bit_position_next;
      key_shift       <= key_shift_next;
      count_shift     <= count_shift_next;
      stop_shift      <= stop_shift_next;
      frame_info.done <= done;
      if (done) begin
        frame_keys       <= key_shift_next;
        frame_info.count <= count_shift_next;
        frame_info.stop  <= stop_shift_next;
        frame_info.valid <= (stop_shift_next == VALID_STOP) &&
                            (count_shift_next < COUNT_LIMIT);
      end
    end
  end

endmodule

/* rtl/core/tkp_key_lane.sv */
module tkp_key_lane
  import tkp_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        upd,
  input  logic        pressed,
  input  logic [15:0] long_press_frames,
  output press_cls_t  cls,
  output press_cls_t  cls_next
);

  localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  logic [COUNT_BITS-1:0] cnt, cnt_next;
  logic [CMP_W-1:0]      cnt_ext, new_ext, lpf_ext;

  assign cnt_ext = CMP_W'(cnt);
  assign new_ext = CMP_W'(cnt_next);
  assign lpf_ext = CMP_W'(long_press_frames);

  always_comb begin
    cnt_next = cnt;
    cls_next = cls;
    if (upd) begin
      if (pressed) begin
        cnt_next = (&cnt) ? cnt : cnt + 1'b1;
      end else begin
        if (cnt != '0 && cnt_ext < lpf_ext) begin
          cls_next = CLS_SHORT;
        end else if (cnt == '0) begin
          cls_next = CLS_NONE;
        end
        cnt_next = '0;
      end
      if (new_ext > lpf_ext) begin
        cls_next = CLS_LONG;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      cls <= CLS_NONE;
    end else begin
      cnt <= cnt_next;
      cls <= cls_next;
    end
  end

endmodule

/* rtl/core/touch_key_frame_press_classifier.sv */
// channel  dir  signals              contents
// s_axis   in   tvalid/tready/tdata  tdata[0] line_level, tuser[0] op
// m_axis   out  tvalid/tready/tdata  tdata: raw_pressed, key_class, any_pressed,
//                                    reported_count, stop_code; tuser[0] frame_valid
// cfg      in   we/wdata             long_press_frames
//
// one serial bit is taken per cycle; a frame result is valid once the frame
// register has loaded with its last bit and the per-key counter update has
// then fed the result register
// rst is synchronous: bit position, shift fields, counters and classes clear
// while a result waits, bits keep flowing; only a frame's last bit is held
// until the result register is free
module touch_key_frame_press_classifier
  import tkp_pkg::*;
#(
  parameter int KEYS       = 8,
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // line_level
  input  logic [0:0]  s_axis_tuser,   // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // raw_pressed, key_class, any_pressed,
                                      // reported_count, stop_code
  output logic [0:0]  m_axis_tuser,   // frame_valid
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

`include "touch_key_frame_press_classifier_assert.svh"

  logic              in_acc;
  logic              at_last;
  logic [KEYS-1:0]   frame_keys;
  frame_info_t       frame_info;
  logic [15:0]       long_press_frames;
  press_cls_t        cls_q [KEYS];
  press_cls_t        cls_n [KEYS];
  logic [2*KEYS-1:0] cls_all;
  logic [OUT_KEYS-1:0]   raw8;
  logic [2*OUT_KEYS-1:0] cls16;

  assign s_axis_tready = !(at_last && (m_axis_tvalid || frame_info.done));
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_frames <= LONG_PRESS_RESET;
    end else if (cfg_we) begin
      long_press_frames <= cfg_wdata;
    end
  end

  tkp_rx #(.KEYS(KEYS)) u_rx (
    .clk        (clk),
    .rst        (rst),
    .in_acc     (in_acc),
    .op         (s_axis_tuser[0]),
    .line_level (s_axis_tdata[0]),
    .at_last    (at_last),
    .frame_keys (frame_keys),
    .frame_info (frame_info)
  );

  for (genvar k = 0; k < KEYS; k++) begin : g_lane
    tkp_key_lane #(.COUNT_BITS(COUNT_BITS)) u_lane (
      .clk               (clk),
      .rst               (rst),
      .upd               (frame_info.done && frame_info.valid),
      .pressed           (frame_keys[k]),
      .long_press_frames (long_press_frames),
      .cls               (cls_q[k]),
      .cls_next          (cls_n[k])
    );
    assign cls_all[2*k +: 2] = cls_q[k];
  end

  for (genvar i = 0; i < OUT_KEYS; i++) begin : g_out
    if (i < KEYS) begin : g_key
      assign raw8[i]         = frame_keys[i];
      assign cls16[2*i +: 2] = cls_n[i];
    end else begin : g_pad
      assign raw8[i]         = 1'b0;
      assign cls16[2*i +: 2] = 2'b00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (frame_info.done) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_info.done) begin
      m_axis_tdata <= {frame_info.stop, frame_info.count, |frame_keys, cls16, raw8};
      m_axis_tuser <= frame_info.valid;
    end
  end

  `TKP_ASSERT_NOW(a_result_slot_free, frame_info.done, !m_axis_tvalid, "result register busy at frame end")
  `TKP_ASSERT_NEXT(a_frame_gives_result, frame_info.done, m_axis_tvalid, "frame end gave no result")
  `TKP_ASSERT_NEXT(a_invalid_keeps_class, !(frame_info.done && frame_info.valid), $stable(cls_all), "classes moved without a valid frame")

endmodule

/* bench/frame_checker.sv */
`timescale 1ns / 1ps

module frame_checker
  import tkp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic [0:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  input  logic [0:0]  m_axis_tuser,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic [7:0]  raw;
    logic [15:0] cls;
    logic        any;
    logic        valid;
    logic [3:0]  count;
    logic [2:0]  stop;
  } frame_result_t;

  localparam int NUM_KEYS   = 8;
  localparam int FRAME_LEN  = NUM_KEYS + 7;
  localparam logic [15:0] HOLD_MAX = 16'hFFFF;

  frame_result_t frame_q[$];
  frame_result_t want;
  frame_result_t got;

  logic [4:0]  bit_pos;
  logic [7:0]  key_sh;
  logic [3:0]  cnt_sh;
  logic [2:0]  stop_sh;
  logic [7:0]  raw_keys;
  logic [15:0] hold_cnt [NUM_KEYS];
  press_cls_t  key_cls [NUM_KEYS];
  logic [15:0] long_limit;

  task take_bit(input logic op, input logic lvl);
    frame_result_t r;
    int p;
    int k;
    p = int'(bit_pos);
    if (!op) begin
      bit_pos = '0;
      key_sh  = '0;
      cnt_sh  = '0;
      stop_sh = '0;
      return;
    end
    if (p >= FRAME_LEN) return;
    if (p < NUM_KEYS) begin
      if (!lvl) key_sh[p] = 1'b1;
    end else if (p < NUM_KEYS + 4) begin
      if (lvl) cnt_sh[p - NUM_KEYS] = 1'b1;
    end else begin
      if (lvl) stop_sh[p - NUM_KEYS - 4] = 1'b1;
    end
    bit_pos = bit_pos + 5'd1;
    if (bit_pos < FRAME_LEN) return;

    // frame complete
    raw_keys = key_sh;
    r.valid  = (stop_sh == VALID_STOP) && (cnt_sh < COUNT_LIMIT);
    if (r.valid) begin
      for (k = 0; k < NUM_KEYS; k++) begin
        if (raw_keys[k]) begin
          if (hold_cnt[k] != HOLD_MAX) hold_cnt[k] = hold_cnt[k] + 16'd1;
        end else begin
          if (hold_cnt[k] > 0 && hold_cnt[k] < long_limit) key_cls[k] = CLS_SHORT;
          else if (hold_cnt[k] == 0) key_cls[k] = CLS_NONE;
          hold_cnt[k] = '0;
        end
        if (hold_cnt[k] > long_limit) key_cls[k] = CLS_LONG;
      end
    end
    r.raw = raw_keys;
    r.cls = '0;
    for (k = 0; k < NUM_KEYS; k++) r.cls[2*k +: 2] = key_cls[k];
    r.any   = (raw_keys != 0);
    r.count = cnt_sh;
    r.stop  = stop_sh;
    frame_q.push_back(r);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      errors     = 0;
      bit_pos    = '0;
      key_sh     = '0;
      cnt_sh     = '0;
      stop_sh    = '0;
      raw_keys   = '0;
      long_limit = LONG_PRESS_RESET;
      for (int k = 0; k < NUM_KEYS; k++) begin
        hold_cnt[k] = '0;
        key_cls[k]  = CLS_NONE;
      end
      frame_q.delete();
    end else begin
      if (cfg_we) long_limit = cfg_wdata;
      if (m_axis_tvalid && m_axis_tready) begin
        got.raw   = m_axis_tdata[7:0];
        got.cls   = m_axis_tdata[23:8];
        got.any   = m_axis_tdata[24];
        got.count = m_axis_tdata[28:25];
        got.stop  = m_axis_tdata[31:29];
        got.valid = m_axis_tuser[0];
        if (frame_q.size() == 0) begin
          errors = errors + 1;
          if (errors <= 10)
            $display("result with nothing expected: raw=%h cls=%h any=%b valid=%b cnt=%0d stop=%0d",
                     got.raw, got.cls, got.any, got.valid, got.count, got.stop);
        end else begin
          want = frame_q.pop_front();
          if (got !== want) begin
            errors = errors + 1;
            if (errors <= 10) begin
              $display("mismatch at %0t", $realtime);
              $display("  expected raw=%h cls=%h any=%b valid=%b cnt=%0d stop=%0d",
                       want.raw, want.cls, want.any, want.valid, want.count, want.stop);
              $display("  actual   raw=%h cls=%h any=%b valid=%b cnt=%0d stop=%0d",
                       got.raw, got.cls, got.any, got.valid, got.count, got.stop);
            end
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) take_bit(s_axis_tuser[0], s_axis_tdata[0]);
    end
    pending <= frame_q.size();
  end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import tkp_pkg::*;

  localparam logic OP_START = 1'b0;
  localparam logic OP_BIT   = 1'b1;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // line_level
  logic [0:0]  s_axis_tuser = '0;   // op
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // raw_pressed, key_class, any_pressed,
                                    // reported_count, stop_code
  logic [0:0]  m_axis_tuser;        // frame_valid
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  int errors;
  int pending;
  int burst_left = 0;
  int items_sent = 0;
  int stall_left = 0;
  int stall_mode = 0;
  logic [7:0] held = '0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  touch_key_frame_press_classifier DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  frame_checker u_checker (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .errors(errors), .pending(pending)
  );

  // receiver stall pattern; the mode is redrawn when its hold counter runs out
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 150);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= ($urandom_range(0, 7) != 0);
      default: m_axis_tready <= (stall_left % 4 == 0);
    endcase
  end

  task automatic put_item(input logic op, input logic lvl);
    int gap;
    logic took;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 250)
                                               : $urandom_range(1, 30);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, lvl};
    s_axis_tuser  <= op;
    do begin
      @(negedge clk);
      took = s_axis_tready;
      @(posedge clk);
    end while (!took);
    burst_left = burst_left - 1;
    items_sent = items_sent + 1;
  endtask

  task automatic send_frame(input logic [7:0] keys, input logic [3:0] cnt,
                            input logic [2:0] stop, input bit with_start);
    if (with_start) put_item(OP_START, 1'($urandom_range(0, 1)));
    for (int k = 0; k < 8; k++) put_item(OP_BIT, !keys[k]);
    for (int k = 0; k < 4; k++) put_item(OP_BIT, cnt[k]);
    for (int k = 0; k < 3; k++) put_item(OP_BIT, stop[k]);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (6) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_long_press(input logic [15:0] frames);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= frames;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic random_traffic(input int quota);
    int stop_at;
    int kind;
    int n;
    logic [7:0] keys;
    logic [3:0] cnt;
    logic [2:0] stop;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      kind = $urandom_range(0, 99);
      case ($urandom_range(0, 11))
        0: held = 8'h00;
        1: held = 8'hFF;
        2, 3: held = held ^ (8'($urandom) & 8'($urandom));
        default: ;
      endcase
      keys = ($urandom_range(0, 9) == 0) ? 8'($urandom) : held;
      cnt  = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 4));
      stop = ($urandom_range(0, 3) == 0) ? 3'($urandom) : VALID_STOP;
      if (kind < 70) begin
        send_frame(keys, cnt, stop, 1'b1);
      end else if (kind < 80) begin
        // aborted frame
        put_item(OP_START, 1'b0);
        n = $urandom_range(0, 14);
        for (int i = 0; i < n; i++) put_item(OP_BIT, 1'($urandom_range(0, 1)));
      end else if (kind < 90) begin
        send_frame(keys, cnt, stop, 1'b1);
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) put_item(OP_BIT, 1'($urandom_range(0, 1)));
      end else begin
        n = $urandom_range(1, 10);
        for (int i = 0; i < n; i++)
          put_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
      if ($urandom_range(0, 14) == 0) drain();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // data bits straight after reset, no start marker
    send_frame(8'hFF, 4'd4, VALID_STOP, 1'b0);
    // trailing bits after a complete frame
    put_item(OP_BIT, 1'b1);
    put_item(OP_BIT, 1'b0);
    // start marker, then a partial frame dropped by the next start
    put_item(OP_START, 1'b1);
    put_item(OP_BIT, 1'b0);
    put_item(OP_BIT, 1'b1);
    put_item(OP_BIT, 1'b0);

    random_traffic(140);
    write_long_press(16'd1);
    random_traffic(140);
    write_long_press(16'd65534);
    random_traffic(140);
    write_long_press(16'd3);
    random_traffic(140);
    write_long_press(16'($urandom_range(2, 40)));
    random_traffic(140);

    drain();
    repeat (10) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
